// ===== rtl/som_two_unit_train_classify_assert.svh =====
// Assertion macros used by the sequencer of the two-unit map RTL.
`ifndef SOM_TWO_UNIT_TRAIN_CLASSIFY_ASSERT_SVH
`define SOM_TWO_UNIT_TRAIN_CLASSIFY_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define SOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked out of reset.
`define SOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SOM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SOM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/som2_pkg.sv =====
// Shared types, codes and constants of the two-unit self-organizing map.
package som2_pkg;

    localparam int UNITS      = 2;
    localparam int VECTOR_LEN = 4;
    localparam int W_DEPTH    = UNITS * VECTOR_LEN;

    localparam logic [15:0] Q15_ONE = 16'd32768;

    // Item kinds
    localparam logic [2:0] KIND_LOAD     = 3'd0;
    localparam logic [2:0] KIND_TRAIN    = 3'd1;
    localparam logic [2:0] KIND_EPOCH    = 3'd2;
    localparam logic [2:0] KIND_CLASSIFY = 3'd3;
    localparam logic [2:0] KIND_RESTART  = 3'd4;

    // Register indexes
    localparam logic [1:0] CFG_INIT_ALPHA = 2'd0;
    localparam logic [1:0] CFG_DECAY      = 2'd1;
    localparam logic [1:0] CFG_FLOOR      = 2'd2;

    localparam logic [15:0] RST_INIT_ALPHA = 16'd3932;
    localparam logic [15:0] RST_DECAY      = 16'd62915;
    localparam logic [15:0] RST_FLOOR      = 16'd655;

    // Weight store index is {unit, element}
    localparam logic [15:0] START_W [W_DEPTH] = '{
        16'd6554,  16'd16384, 16'd26214, 16'd22938,
        16'd19661, 16'd29491, 16'd13107, 16'd9830
    };

    // Sequencer counter: eight squares plus one drain step, four updates plus one
    localparam logic [3:0] DIST_LAST = 4'd8;
    localparam logic [3:0] UPD_LAST  = 4'd4;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_UPD,
        MUL_DECAY
    } t_mul_sel;

    typedef struct packed {
        logic       start;
        logic       load_w;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic [2:0] mul_idx;
        logic       acc_en;
        logic       wr_en;
        logic       alpha_decay;
        logic       restart;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic train_ok;
    } t_status;

endpackage

// ===== rtl/som2_ctrl.sv =====
// Sequencer for the two-unit map: steps the shared multiplier and the output register.
`include "som_two_unit_train_classify_assert.svh"
module som2_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [2:0]      i_kind,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  som2_pkg::t_status i_status,
    output som2_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIST,
        S_UPD,
        S_DECAY_MUL,
        S_DECAY_WR,
        S_RESTART,
        S_FINISH
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic [2:0] r_kind;
    logic       r_out_valid;
    logic       accept;
    logic       out_free;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = som2_pkg::MUL_SQ;
        o_cmd.mul_idx = r_cnt[2:0];
        o_cmd.start   = accept;
        case (r_state)
            S_LOAD: begin
                o_cmd.load_w = 1'b1;
            end
            S_DIST: begin
                o_cmd.mul_en = (r_cnt < som2_pkg::DIST_LAST);
                o_cmd.acc_en = (r_cnt != 4'd0);
            end
            S_UPD: begin
                o_cmd.mul_sel = som2_pkg::MUL_UPD;
                o_cmd.mul_en  = (r_cnt < som2_pkg::UPD_LAST);
                o_cmd.wr_en   = (r_cnt != 4'd0);
            end
            S_DECAY_MUL: begin
                o_cmd.mul_sel = som2_pkg::MUL_DECAY;
                o_cmd.mul_en  = 1'b1;
            end
            S_DECAY_WR: begin
                o_cmd.alpha_decay = 1'b1;
            end
            S_RESTART: begin
                o_cmd.restart = 1'b1;
            end
            S_FINISH: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.start = accept;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_kind      <= som2_pkg::KIND_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        r_kind <= i_kind;
                        case (i_kind)
                            som2_pkg::KIND_LOAD:     r_state <= S_LOAD;
                            som2_pkg::KIND_TRAIN,
                            som2_pkg::KIND_CLASSIFY: r_state <= S_DIST;
                            som2_pkg::KIND_EPOCH:    r_state <= S_DECAY_MUL;
                            som2_pkg::KIND_RESTART:  r_state <= S_RESTART;
                            default:                 r_state <= S_FINISH;
                        endcase
                    end
                end
                S_DIST: begin
                    if (r_cnt == som2_pkg::DIST_LAST) begin
                        r_cnt <= '0;
                        if (r_kind == som2_pkg::KIND_TRAIN && i_status.train_ok) begin
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_UPD: begin
                    if (r_cnt == som2_pkg::UPD_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DECAY_MUL: r_state <= S_DECAY_WR;
                S_LOAD,
                S_DECAY_WR,
                S_RESTART:   r_state <= S_FINISH;
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SOM_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    `SOM_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `SOM_ASSERT_IMPL(a_dist_cnt_range, i_clk, i_rst_n, r_state == S_DIST, r_cnt <= som2_pkg::DIST_LAST)
    `SOM_ASSERT_IMPL(a_upd_only_train, i_clk, i_rst_n, r_state == S_UPD, r_kind == som2_pkg::KIND_TRAIN)

endmodule

// ===== rtl/som2_dp.sv =====
// Datapath of the two-unit map: weights, learning rate, shared multiplier, result register.
module som2_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  som2_pkg::t_cmd i_cmd,
    output som2_pkg::t_status o_status,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [2:0]     i_kind,
    input  logic [15:0]    i_sample_0,
    input  logic [15:0]    i_sample_1,
    input  logic [15:0]    i_sample_2,
    input  logic [15:0]    i_sample_3,
    input  logic           i_unit_select,
    output logic           o_winner,
    output logic [32:0]    o_distance_unit0,
    output logic [32:0]    o_distance_unit1,
    output logic           o_weights_updated,
    output logic           o_training_done,
    output logic [15:0]    o_alpha_now
);

    logic [15:0]        r_x [som2_pkg::VECTOR_LEN];
    logic               r_sel;
    logic               r_is_dist;
    logic [15:0]        r_w [som2_pkg::W_DEPTH];
    logic [15:0]        r_alpha;
    logic [15:0]        r_init;
    logic [15:0]        r_decay;
    logic [15:0]        r_floor;
    logic [32:0]        r_acc0;
    logic [32:0]        r_acc1;
    logic signed [35:0] r_prod;
    logic [2:0]         r_pidx;
    logic [15:0]        r_wold;
    logic               r_upd;
    logic               r_winner;
    logic [32:0]        r_dist0;
    logic [32:0]        r_dist1;
    logic               r_updated;
    logic               r_done;
    logic [15:0]        r_alpha_out;

    logic [15:0]        samp [som2_pkg::VECTOR_LEN];
    logic               win;
    logic [2:0]         rd_idx;
    logic [15:0]        w_rd;
    logic [15:0]        x_rd;
    logic signed [16:0] diff;
    logic [15:0]        absd;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] prod;
    logic signed [19:0] delta;
    logic signed [20:0] wsum;
    logic [15:0]        n_weight;

    assign samp[0] = i_sample_0;
    assign samp[1] = i_sample_1;
    assign samp[2] = i_sample_2;
    assign samp[3] = i_sample_3;

    // Unit 0 wins only on a strictly smaller distance
    assign win    = (r_acc0 < r_acc1) ? 1'b0 : 1'b1;
    assign rd_idx = (i_cmd.mul_sel == som2_pkg::MUL_UPD) ? {win, i_cmd.mul_idx[1:0]}
                                                         : i_cmd.mul_idx;
    assign w_rd   = r_w[rd_idx];
    assign x_rd   = r_x[rd_idx[1:0]];
    assign diff   = $signed({1'b0, x_rd}) - $signed({1'b0, w_rd});
    assign absd   = diff[16] ? 16'(-diff) : diff[15:0];

    always_comb begin
        case (i_cmd.mul_sel)
            som2_pkg::MUL_SQ: begin
                mul_a = $signed({2'b00, absd});
                mul_b = $signed({2'b00, absd});
            end
            som2_pkg::MUL_UPD: begin
                mul_a = $signed({2'b00, r_alpha});
                mul_b = $signed({diff[16], diff});
            end
            som2_pkg::MUL_DECAY: begin
                mul_a = $signed({2'b00, r_alpha});
                mul_b = $signed({2'b00, r_decay});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Floor shift of the update product, then clamp into 0..1.0
    assign delta = r_prod[35:16];
    assign wsum  = $signed({5'b00000, r_wold}) + $signed({delta[19], delta});
    always_comb begin
        if (wsum < 0) begin
            n_weight = '0;
        end else if (wsum > $signed({5'b00000, som2_pkg::Q15_ONE})) begin
            n_weight = som2_pkg::Q15_ONE;
        end else begin
            n_weight = wsum[15:0];
        end
    end

    assign o_status.train_ok = (r_alpha > r_floor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= som2_pkg::START_W;
            r_alpha <= som2_pkg::RST_INIT_ALPHA;
            r_init  <= som2_pkg::RST_INIT_ALPHA;
            r_decay <= som2_pkg::RST_DECAY;
            r_floor <= som2_pkg::RST_FLOOR;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    som2_pkg::CFG_INIT_ALPHA: r_init  <= i_cfg_data;
                    som2_pkg::CFG_DECAY:      r_decay <= i_cfg_data;
                    som2_pkg::CFG_FLOOR:      r_floor <= i_cfg_data;
                    default:                  r_init  <= r_init;
                endcase
            end
            if (i_cmd.load_w) begin
                for (int e = 0; e < som2_pkg::VECTOR_LEN; e++) begin
                    r_w[{r_sel, 2'(e)}] <= r_x[e];
                end
            end
            if (i_cmd.wr_en) begin
                r_w[r_pidx] <= n_weight;
            end
            if (i_cmd.alpha_decay) begin
                r_alpha <= r_prod[31:16];
            end
            if (i_cmd.restart) begin
                r_alpha <= r_init;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int e = 0; e < som2_pkg::VECTOR_LEN; e++) begin
                r_x[e] <= (samp[e] > som2_pkg::Q15_ONE) ? som2_pkg::Q15_ONE : samp[e];
            end
            r_sel     <= i_unit_select;
            r_is_dist <= (i_kind == som2_pkg::KIND_TRAIN) || (i_kind == som2_pkg::KIND_CLASSIFY);
            r_acc0    <= '0;
            r_acc1    <= '0;
            r_upd     <= 1'b0;
        end else begin
            if (i_cmd.acc_en) begin
                if (r_pidx[2]) begin
                    r_acc1 <= r_acc1 + r_prod[32:0];
                end else begin
                    r_acc0 <= r_acc0 + r_prod[32:0];
                end
            end
            if (i_cmd.wr_en && (n_weight != r_wold)) begin
                r_upd <= 1'b1;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
            r_pidx <= rd_idx;
            r_wold <= w_rd;
        end
        if (i_cmd.out_load) begin
            r_winner    <= r_is_dist ? win : 1'b0;
            r_dist0     <= r_acc0;
            r_dist1     <= r_acc1;
            r_updated   <= r_upd;
            r_done      <= (r_alpha <= r_floor);
            r_alpha_out <= r_alpha;
        end
    end

    assign o_winner          = r_winner;
    assign o_distance_unit0  = r_dist0;
    assign o_distance_unit1  = r_dist1;
    assign o_weights_updated = r_updated;
    assign o_training_done   = r_done;
    assign o_alpha_now       = r_alpha_out;

endmodule

// ===== rtl/som_two_unit_train_classify.sv =====
// Top level of the two-unit self-organizing map with train and classify items.
//
// Input channel: i_in_valid / o_in_stall with the item fields i_kind, i_sample_0..3
// and i_unit_select. An item transfers at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with the result fields; one result per item.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; ready is
// always high, index 3 is dropped. Write registers only while the block is idle.
//
// Steps from an input transfer to the load of the result register, paced by one
// shared 18x18 multiplier that computes each square and each weight step in turn:
//   classify (eight squares, a drain step, the load), train (as classify, plus the
//   four weight steps and their drain unless training is done), end epoch (decay
//   multiply, rate write, load), load and restart (their step, then the load),
//   unused kinds (the load alone).
// The input stalls until the result is loaded and the block is idle again.
// A held result does not block a new item: the block takes it and works on it, and
// waits at the end only if the previous result is still stalled.
// Reset (synchronous, active low) restores the starting weights, the register
// defaults and the starting learning rate, and empties the output register.
module som_two_unit_train_classify (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_sample_0,
    input  logic [15:0] i_sample_1,
    input  logic [15:0] i_sample_2,
    input  logic [15:0] i_sample_3,
    input  logic        i_unit_select,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_winner,
    output logic [32:0] o_distance_unit0,
    output logic [32:0] o_distance_unit1,
    output logic        o_weights_updated,
    output logic        o_training_done,
    output logic [15:0] o_alpha_now,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    som2_pkg::t_cmd    cmd;
    som2_pkg::t_status status;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    som2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    som2_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_kind),
        .i_sample_0        (i_sample_0),
        .i_sample_1        (i_sample_1),
        .i_sample_2        (i_sample_2),
        .i_sample_3        (i_sample_3),
        .i_unit_select     (i_unit_select),
        .o_winner          (o_winner),
        .o_distance_unit0  (o_distance_unit0),
        .o_distance_unit1  (o_distance_unit1),
        .o_weights_updated (o_weights_updated),
        .o_training_done   (o_training_done),
        .o_alpha_now       (o_alpha_now)
    );

endmodule
